FILE: src/dctd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dctd_pkg
// Shared constants and types for the trial-division divisor counter.
// ----------------------------------------------------------------------------
package dctd_pkg;

	localparam int unsigned PRIME_LIMIT = 8192;
	localparam int unsigned PRIME_COUNT = 1028;

	localparam int unsigned VALUE_W   = 63;
	localparam int unsigned COUNT_W   = 18;
	localparam int unsigned COUNT_MAX = (2 ** COUNT_W) - 1;

	// prime and sieve index width, table address and fill count widths
	localparam int unsigned PRIME_W = $clog2(PRIME_LIMIT);
	localparam int unsigned TAB_W   = $clog2(PRIME_COUNT);
	localparam int unsigned CNT_W   = $clog2(PRIME_COUNT + 1);

	// an exponent of a prime >= 2 stays below VALUE_W
	localparam int unsigned EXP_W = $clog2(VALUE_W);

	// divider retires DIV_BITS quotient bits per cycle
	localparam int unsigned DIV_BITS  = 4;
	localparam int unsigned DIV_STEPS = (VALUE_W + DIV_BITS - 1) / DIV_BITS;
	localparam int unsigned PAD_W     = DIV_STEPS * DIV_BITS;
	localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

	typedef struct packed {
		logic               en;
		logic [TAB_W-1:0]   addr;
		logic [PRIME_W-1:0] data;
	} tab_wr_t;

	typedef struct packed {
		logic             done;
		logic [CNT_W-1:0] count;
	} sieve_stat_t;

	typedef struct packed {
		logic               start;
		logic [VALUE_W-1:0] dividend;
		logic [PRIME_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [VALUE_W-1:0] quotient;
		logic               rem_zero;
	} div_rsp_t;

endpackage
`default_nettype wire

FILE: src/dctd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dctd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dctd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

FILE: src/dctd_sieve.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dctd_sieve
// Sieve of Eratosthenes run once after reset; streams primes into the table.
// ----------------------------------------------------------------------------
module dctd_sieve (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	output dctd_pkg::tab_wr_t          tab_wr,
	output dctd_pkg::sieve_stat_t      stat
);
	import dctd_pkg::*;

	localparam int unsigned SQ_W = 2 * (PRIME_W + 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_READ,
		ST_CHECK,
		ST_MARK,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic [PRIME_W-1:0] clr_q;
	logic [PRIME_W:0]   i_q;
	logic [PRIME_W:0]   j_q;
	logic [CNT_W-1:0]   cnt_q;

	logic [SQ_W-1:0]    sq;
	logic [PRIME_W:0]   next_i;
	logic [PRIME_W:0]   next_j;
	logic               last_i;
	logic               comp_rd;
	logic               comp_wr_en;
	logic [PRIME_W-1:0] comp_wr_addr;
	logic               comp_wr_data;

	assign sq     = SQ_W'(i_q) * SQ_W'(i_q);
	assign next_i = i_q + 1'b1;
	assign next_j = j_q + i_q;
	assign last_i = (next_i == (PRIME_W + 1)'(PRIME_LIMIT));

	always_comb begin
		comp_wr_en   = 1'b0;
		comp_wr_addr = clr_q;
		comp_wr_data = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				comp_wr_en = 1'b1;
			end
			ST_MARK: begin
				comp_wr_en   = 1'b1;
				comp_wr_addr = j_q[PRIME_W-1:0];
				comp_wr_data = 1'b1;
			end
			default: begin
				comp_wr_en = 1'b0;
			end
		endcase
	end

	// composite flags, one bit per candidate
	dctd_ram #(
		.WIDTH(1),
		.DEPTH(PRIME_LIMIT)
	) u_comp_ram (
		.clk     (clk),
		.wr_en   (comp_wr_en),
		.wr_addr (comp_wr_addr),
		.wr_data (comp_wr_data),
		.rd_en   (state_q == ST_READ),
		.rd_addr (i_q[PRIME_W-1:0]),
		.rd_data (comp_rd)
	);

	assign tab_wr.en   = (state_q == ST_CHECK) && !comp_rd && (cnt_q < CNT_W'(PRIME_COUNT));
	assign tab_wr.addr = cnt_q[TAB_W-1:0];
	assign tab_wr.data = i_q[PRIME_W-1:0];

	assign stat.done  = (state_q == ST_DONE);
	assign stat.count = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == PRIME_W'(PRIME_LIMIT - 1)) begin
						i_q     <= (PRIME_W + 1)'(2);
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (tab_wr.en) begin
						cnt_q <= cnt_q + 1'b1;
					end
					// marking starts at i*i; past the limit there is nothing to mark
					if (!comp_rd && (sq < SQ_W'(PRIME_LIMIT))) begin
						j_q     <= sq[PRIME_W:0];
						state_q <= ST_MARK;
					end else begin
						i_q     <= next_i;
						state_q <= last_i ? ST_DONE : ST_READ;
					end
				end
				ST_MARK: begin
					j_q <= next_j;
					if (next_j >= (PRIME_W + 1)'(PRIME_LIMIT)) begin
						i_q     <= next_i;
						state_q <= last_i ? ST_DONE : ST_READ;
					end
				end
				ST_DONE: begin
					state_q <= ST_DONE;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: src/dctd_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dctd_div
// Iterative restoring divider: wide value by a table prime, four bits a cycle.
// ----------------------------------------------------------------------------
module dctd_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dctd_pkg::div_req_t req,
	output dctd_pkg::div_rsp_t      rsp
);
	import dctd_pkg::*;

	logic               busy_q;
	logic               done_q;
	logic [STEP_W-1:0]  step_q;
	logic [PAD_W-1:0]   shift_q;
	logic [PRIME_W-1:0] rem_q;
	logic [PRIME_W-1:0] d_q;

	logic [PRIME_W:0]   r;
	logic [PAD_W-1:0]   s;

	// dividend bits leave at the top, quotient bits enter at the bottom
	always_comb begin
		r = {1'b0, rem_q};
		s = shift_q;
		for (int k = 0; k < DIV_BITS; k++) begin
			r = {r[PRIME_W-1:0], s[PAD_W-1]};
			s = {s[PAD_W-2:0], 1'b0};
			if (r >= {1'b0, d_q}) begin
				r    = r - {1'b0, d_q};
				s[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			shift_q <= PAD_W'(req.dividend);
			rem_q   <= '0;
			d_q     <= req.divisor;
		end else if (busy_q) begin
			shift_q <= s;
			rem_q   <= r[PRIME_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = shift_q[VALUE_W-1:0];
	assign rsp.rem_zero = (rem_q == '0);

endmodule
`default_nettype wire

FILE: src/divisor_count_trial_division.sv
`default_nettype none
// ----------------------------------------------------------------------------
// divisor_count_trial_division
// Counts divisors of a value by trial division over a sieve-built prime table.
// ----------------------------------------------------------------------------
// sequence: per table prime tried, a fetch from the prime table and e + 1
//   trial divisions for exponent e
// throughput: one item at a time; the next item is taken once the walk ends
//   and its result has been loaded into the output register
// reset: the sieve clears its 8192 flags, then fills the prime table; no item
//   is accepted until it finishes
module divisor_count_trial_division (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [dctd_pkg::VALUE_W-1:0]    value,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [dctd_pkg::COUNT_W-1:0]    divisor_count,
	output logic      [dctd_pkg::VALUE_W-1:0]    residue,
	output logic                                 residue_left
);
	import dctd_pkg::*;

	localparam int unsigned PROD_W = COUNT_W + EXP_W + 1;

	typedef enum logic [2:0] {
		ST_SIEVE,
		ST_IDLE,
		ST_FETCH,
		ST_DIVIDE,
		ST_WAIT,
		ST_FINISH
	} state_t;

	state_t             state_q;
	logic [VALUE_W-1:0] x_q;
	logic [COUNT_W-1:0] count_q;
	logic [CNT_W-1:0]   idx_q;
	logic [EXP_W-1:0]   exp_q;
	logic               out_valid_q;
	logic [COUNT_W-1:0] divisor_count_q;
	logic [VALUE_W-1:0] residue_q;
	logic               residue_left_q;

	tab_wr_t            tab_wr;
	sieve_stat_t        sieve_stat;
	div_req_t           div_req;
	div_rsp_t           div_rsp;
	logic [PRIME_W-1:0] prime;

	logic [EXP_W:0]     exp_inc;
	logic [PROD_W-1:0]  prod;
	logic [COUNT_W-1:0] count_next;
	logic [CNT_W-1:0]   idx_next;
	logic               in_beat;
	logic               load_out;

	dctd_sieve u_sieve (
		.clk    (clk),
		.arst_n (arst_n),
		.tab_wr (tab_wr),
		.stat   (sieve_stat)
	);

	dctd_ram #(
		.WIDTH(PRIME_W),
		.DEPTH(PRIME_COUNT)
	) u_prime_ram (
		.clk     (clk),
		.wr_en   (tab_wr.en),
		.wr_addr (tab_wr.addr),
		.wr_data (tab_wr.data),
		.rd_en   (state_q == ST_FETCH),
		.rd_addr (idx_q[TAB_W-1:0]),
		.rd_data (prime)
	);

	assign div_req.start    = (state_q == ST_DIVIDE);
	assign div_req.dividend = x_q;
	assign div_req.divisor  = prime;

	dctd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// fold exponent into the running count, saturating
	assign exp_inc    = {1'b0, exp_q} + 1'b1;
	assign prod       = PROD_W'(count_q) * PROD_W'(exp_inc);
	assign count_next = (prod > PROD_W'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
	                                                : prod[COUNT_W-1:0];
	assign idx_next   = idx_q + 1'b1;

	assign in_ready = (state_q == ST_IDLE);
	assign in_beat  = in_valid && in_ready;
	assign load_out = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SIEVE;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_SIEVE: begin
					if (sieve_stat.done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_beat) begin
						if ((value <= VALUE_W'(1)) || (sieve_stat.count == '0)) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_FETCH;
						end
					end
				end
				ST_FETCH: begin
					state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (div_rsp.done) begin
						if (div_rsp.rem_zero) begin
							state_q <= ST_DIVIDE;
						end else if ((idx_next == sieve_stat.count) || (x_q <= VALUE_W'(1))) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_FETCH;
						end
					end
				end
				ST_FINISH: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_SIEVE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			x_q     <= value;
			count_q <= COUNT_W'(1);
			idx_q   <= '0;
			exp_q   <= '0;
		end else if ((state_q == ST_WAIT) && div_rsp.done) begin
			if (div_rsp.rem_zero) begin
				x_q   <= div_rsp.quotient;
				exp_q <= exp_q + 1'b1;
			end else begin
				if (exp_q != '0) begin
					count_q <= count_next;
				end
				exp_q <= '0;
				idx_q <= idx_next;
			end
		end
		if (load_out) begin
			divisor_count_q <= count_q;
			residue_q       <= x_q;
			residue_left_q  <= (x_q > VALUE_W'(1));
		end
	end

	assign out_valid     = out_valid_q;
	assign divisor_count = divisor_count_q;
	assign residue       = residue_q;
	assign residue_left  = residue_left_q;

`ifndef SYNTHESIS
	a_ready_after_sieve: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> sieve_stat.done)
		else $error("input taken before prime table is built");

	a_fetch_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH) |-> (idx_q < sieve_stat.count))
		else $error("table fetch beyond filled entries");

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_WAIT))
		else $error("divider finished outside of wait state");

	a_exact_div_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_WAIT) && div_rsp.done && div_rsp.rem_zero) |=> (x_q < $past(x_q)))
		else $error("exact division did not reduce the value");

	a_flag_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (residue_left_q == (residue_q > VALUE_W'(1))))
		else $error("residue flag disagrees with residue");
`endif

endmodule
`default_nettype wire
